/* sv/blps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package blps_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } status_t;

  typedef enum logic {
    REG_LED_COUNT       = 1'b0,
    REG_FOUR_COLOR_MASK = 1'b1
  } reg_index_t;

  localparam int unsigned LED_COUNT_W    = 11;
  localparam int unsigned MASK_W         = 32;
  localparam int unsigned COLOR_W        = 32;
  localparam int unsigned BASE_W         = 15;
  localparam logic [10:0] LED_COUNT_RST  = 11'd1024;
  localparam logic [4:0]  LAST_BIT_FOUR  = 5'd31;
  localparam logic [4:0]  LAST_BIT_THREE = 5'd23;

  typedef struct packed {
    opcode_t     opcode;
    logic [4:0]  channel;
    logic [9:0]  led_index;
    logic [31:0] color_value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_color;
    status_t     status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_err;
    logic last_issue;
    logic clr_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* sv/bitplane_led_pixel_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bit-transposed frame store for up to 32 parallel LED strings.
// Request: start with req (opcode, channel, led_index, color_value) is taken
// at a clock edge where busy is low. Each request gives one response: done
// is high for one cycle with rsp (read_color, status); the receiver cannot
// hold it off. Config writes (cfg_we, cfg_index, cfg_data) are taken at once
// and belong only to idle periods.
// Sequence: after accept, one word is read per color bit of the channel's
// format, then a drain state and the done cycle follow; the next request can
// be accepted in the done cycle. An out-of-range request answers in the next
// cycle. Each color bit is one read-modify-write on the single frame store:
// one memory read and one write per cycle, pipelined by a stage.
// Reset: led_count goes to 1024, the four-color mask to zero, and a clearing
// pass writes zero to all MAX_LEDS*32 words, one per cycle, while busy stays
// high.
module bitplane_led_pixel_store #(
  parameter int unsigned MAX_LEDS = 1024,
  parameter int unsigned CHANNELS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire blps_pkg::req_t       req,
  output logic                      busy,
  output logic                      done,
  output blps_pkg::rsp_t            rsp,
  input  wire logic                 cfg_we,
  input  wire blps_pkg::reg_index_t cfg_index,
  input  wire logic [31:0]          cfg_data
);

  blps_pkg::ctrl_cmd_t cmd;
  blps_pkg::ctrl_sts_t sts;

  blps_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  blps_datapath #(
    .MAX_LEDS (MAX_LEDS),
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

/* sv/blps_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module blps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire blps_pkg::ctrl_sts_t sts,
  output blps_pkg::ctrl_cmd_t     cmd,
  output logic                    busy,
  output logic                    done
);

  blps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blps_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = 1'b1;
    done         = 1'b0;
    unique case (state)
      blps_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = blps_pkg::ST_IDLE;
        end
      end
      blps_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sts.req_err ? blps_pkg::ST_DONE : blps_pkg::ST_RUN;
        end
      end
      blps_pkg::ST_RUN: begin
        cmd.rd_issue = 1'b1;
        if (sts.last_issue) begin
          state_next = blps_pkg::ST_DRAIN;
        end
      end
      blps_pkg::ST_DRAIN: begin
        state_next = blps_pkg::ST_DONE;
      end
      blps_pkg::ST_DONE: begin
        busy = 1'b0;
        done = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sts.req_err ? blps_pkg::ST_DONE : blps_pkg::ST_RUN;
        end else begin
          state_next = blps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = blps_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/blps_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module blps_datapath #(
  parameter int unsigned MAX_LEDS = 1024,
  parameter int unsigned CHANNELS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire blps_pkg::reg_index_t cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire blps_pkg::req_t      req,
  input  wire blps_pkg::ctrl_cmd_t cmd,
  output blps_pkg::ctrl_sts_t      sts,
  output blps_pkg::rsp_t           rsp
);

  localparam int unsigned DEPTH = MAX_LEDS * 32;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [CHANNELS-1:0] mem [DEPTH];

  logic [blps_pkg::LED_COUNT_W-1:0] led_count;
  logic [blps_pkg::MASK_W-1:0]      four_color_mask;

  blps_pkg::opcode_t   op_r;
  logic                err_r;
  logic                four_r;
  logic [CHANNELS-1:0] chmask_r;
  logic [AW-1:0]       base_r;
  logic [4:0]          rcnt;
  logic                dval;
  logic [AW-1:0]       waddr_r;
  logic [AW-1:0]       clr_addr;
  logic [CHANNELS-1:0] rdata;
  logic [31:0]         sh;

  logic [CHANNELS-1:0]        chmask;
  logic [blps_pkg::BASE_W-1:0] base_calc;
  logic [AW-1:0]              raddr;
  logic                       rd_bit;
  logic [CHANNELS-1:0]        wdata;
  logic                       four_in;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count       <= blps_pkg::LED_COUNT_RST;
      four_color_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        blps_pkg::REG_LED_COUNT:       led_count <= cfg_data[blps_pkg::LED_COUNT_W-1:0];
        blps_pkg::REG_FOUR_COLOR_MASK: four_color_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // request decode and status
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      chmask[c] = (req.channel == 5'(c));
    end
    four_in     = four_color_mask[req.channel];
    base_calc   = four_in ? {req.led_index, 5'b0}
                          : ({1'b0, req.led_index, 4'b0} + {2'b0, req.led_index, 3'b0});
    sts.req_err = ({1'b0, req.led_index} >= led_count)
               || (32'(req.led_index) >= 32'(MAX_LEDS))
               || (32'(req.channel) >= 32'(CHANNELS));
    sts.last_issue = (rcnt == (four_r ? blps_pkg::LAST_BIT_FOUR
                                      : blps_pkg::LAST_BIT_THREE));
    sts.clr_last   = (clr_addr == AW'(DEPTH - 1));
  end

  assign raddr          = base_r + AW'(rcnt);
  assign rd_bit         = |(rdata & chmask_r);
  assign wdata          = (rdata & ~chmask_r) | (sh[31] ? chmask_r : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dval     <= 1'b0;
      clr_addr <= '0;
      rcnt     <= '0;
    end else begin
      dval <= cmd.rd_issue;
      if (cmd.clear) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.load) begin
        rcnt <= '0;
      end else if (cmd.rd_issue) begin
        rcnt <= rcnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= req.opcode;
      err_r    <= sts.req_err;
      four_r   <= four_in;
      chmask_r <= chmask;
      base_r   <= AW'(base_calc);
      sh       <= req.color_value;
    end else if (dval) begin
      sh <= {sh[30:0], rd_bit};
    end
    if (cmd.rd_issue) begin
      waddr_r <= raddr;
    end
  end

  // frame store: one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= '0;
    end else if (dval && op_r == blps_pkg::OP_WRITE) begin
      mem[waddr_r] <= wdata;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    rsp.read_color = '0;
    rsp.status     = err_r ? blps_pkg::STATUS_RANGE : blps_pkg::STATUS_OK;
    if (!err_r && op_r == blps_pkg::OP_READ) begin
      rsp.read_color = four_r ? sh : {sh[23:0], 8'b0};
    end
  end

endmodule

`default_nettype wire

/* verif/pixel_store_checker.sv */
`timescale 1ns / 1ps

module pixel_store_checker
  import blps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        req,
  input  logic        done,
  input  rsp_t        rsp,
  input  logic        cfg_we,
  input  reg_index_t  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int unsigned STORE_DEPTH = 32768;

  logic [31:0] plane_mem [STORE_DEPTH];
  logic [10:0] led_count_m;
  logic [31:0] four_mask_m;
  rsp_t        answer_q [$];
  int          errors;

  // scatter or gather one pixel in the transposed store
  function automatic rsp_t pixel_access(req_t r);
    rsp_t        o;
    logic        four;
    int unsigned nbits;
    int unsigned base;
    logic [31:0] val;
    o.read_color = '0;
    o.status     = STATUS_OK;
    if ({1'b0, r.led_index} >= led_count_m) begin
      o.status = STATUS_RANGE;
      return o;
    end
    four  = four_mask_m[r.channel];
    nbits = four ? 32 : 24;
    base  = nbits * r.led_index;
    val   = four ? r.color_value : (r.color_value >> 8);
    for (int unsigned i = 0; i < nbits; i++) begin
      if (r.opcode == OP_WRITE) begin
        plane_mem[base + i][r.channel] = val[nbits - 1 - i];
      end else begin
        o.read_color[31 - i] = plane_mem[base + i][r.channel];
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int a = 0; a < STORE_DEPTH; a++) plane_mem[a] = '0;
      led_count_m = LED_COUNT_RST;
      four_mask_m = '0;
      answer_q.delete();
    end else begin
      if (done) begin
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected response: color %h status %0d", rsp.read_color, rsp.status);
        end else begin
          want = answer_q.pop_front();
          if (rsp.read_color !== want.read_color || rsp.status !== want.status) begin
            errors++;
            if (errors <= 10)
              $display("response mismatch: expected color %h status %0d, got color %h status %0d",
                       want.read_color, want.status, rsp.read_color, rsp.status);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LED_COUNT:       led_count_m = cfg_data[10:0];
          REG_FOUR_COLOR_MASK: four_mask_m = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) answer_q.push_back(pixel_access(req));
    end
    fail_count <= errors;
    pending    <= answer_q.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import blps_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  req_t        req = '0;
  logic        busy;
  logic        done;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  reg_index_t  cfg_index = REG_LED_COUNT;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          cycle_cnt = 0;
  logic [10:0] cur_count = LED_COUNT_RST;
  logic        no_gaps = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bitplane_led_pixel_store u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_store_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("bitplane_led_pixel_store verification failed");
      $finish;
    end
  end

  function automatic req_t pixel_req(opcode_t op, logic [4:0] ch, logic [9:0] idx,
                                     logic [31:0] color);
    req_t r;
    r.opcode      = op;
    r.channel     = ch;
    r.led_index   = idx;
    r.color_value = color;
    return r;
  endfunction

  function automatic int gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 80) return $urandom_range(1, 8);
    if (p < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  // half the time one of leds 0 to 7 so reads find earlier writes, some near the count limit
  function automatic logic [9:0] pick_index();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 5) return 10'($urandom_range(0, 7));
    if (p < 7) return 10'(int'(cur_count) - 1 + int'($urandom_range(0, 2)));
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic send(req_t r);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_config(logic [10:0] count, logic [31:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LED_COUNT;
    cfg_data  <= {21'b0, count};
    @(posedge clk);
    cfg_index <= REG_FOUR_COLOR_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_count = count;
  endtask

  initial begin
    logic [10:0] count;
    logic [31:0] mask;
    logic [4:0]  ch;
    logic [9:0]  idx;
    int          n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy);

    // reset layout, cleared store
    send(pixel_req(OP_READ, 5'd0, 10'd0, 32'hFFFF_FFFF));
    send(pixel_req(OP_WRITE, 5'd0, 10'd1023, 32'hFFFF_FFFF));
    send(pixel_req(OP_READ, 5'd0, 10'd1023, 32'h0));
    send(pixel_req(OP_WRITE, 5'd31, 10'd0, 32'hA5C3_5A3C));
    send(pixel_req(OP_READ, 5'd31, 10'd0, 32'h0));
    send(pixel_req(OP_READ, 5'd30, 10'd0, 32'h0));
    drain();

    set_config(11'd1024, 32'hFFFF_FFFF);
    send(pixel_req(OP_WRITE, 5'd31, 10'd1023, 32'hFFFF_FFFF));
    send(pixel_req(OP_READ, 5'd31, 10'd1023, 32'h0));
    send(pixel_req(OP_WRITE, 5'd0, 10'd0, 32'h0000_0001));
    send(pixel_req(OP_READ, 5'd0, 10'd0, 32'h0));
    send(pixel_req(OP_READ, 5'd31, 10'd0, 32'h0));
    drain();

    // overlapping words between a four-color and a three-color channel
    set_config(11'd1024, 32'hAAAA_AAAA);
    send(pixel_req(OP_WRITE, 5'd1, 10'd5, 32'h1234_5678));
    send(pixel_req(OP_WRITE, 5'd2, 10'd6, 32'hFEDC_BA98));
    send(pixel_req(OP_READ, 5'd1, 10'd5, 32'h0));
    send(pixel_req(OP_READ, 5'd2, 10'd6, 32'h0));
    drain();

    set_config(11'd0, 32'hAAAA_AAAA);
    send(pixel_req(OP_WRITE, 5'd3, 10'd0, 32'hFFFF_FFFF));
    send(pixel_req(OP_READ, 5'd3, 10'd0, 32'h0));
    drain();

    set_config(11'd1, 32'h0);
    send(pixel_req(OP_READ, 5'd0, 10'd0, 32'h0));
    send(pixel_req(OP_WRITE, 5'd0, 10'd1, 32'h8000_0001));
    drain();

    set_config(11'd2047, 32'h0);
    send(pixel_req(OP_READ, 5'd0, 10'd1023, 32'h0));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin count = 11'd1024; mask = $urandom; end
        1: begin count = 11'd2047; mask = 32'hFFFF_FFFF; end
        2: begin count = 11'($urandom_range(1, 16)); mask = $urandom; end
        3: begin count = 11'd1024; mask = 32'h0; end
        4: begin count = 11'($urandom_range(1, 1024)); mask = $urandom; end
        5: begin count = 11'd1; mask = $urandom; end
        6: begin count = 11'($urandom_range(1000, 1024)); mask = 32'h5555_5555; end
        7: begin count = 11'd1024; mask = $urandom; end
        default: begin count = 11'($urandom_range(2, 64)); mask = $urandom; end
      endcase
      set_config(count, mask);
      no_gaps = (ph % 4 == 1);
      n = 0;
      while (n < PHASE_ITEMS) begin
        ch  = 5'($urandom_range(0, 31));
        idx = pick_index();
        if ($urandom_range(0, 3) == 0) begin
          // write then read back the same pixel
          send(pixel_req(OP_WRITE, ch, idx, $urandom));
          send(pixel_req(OP_READ, ch, idx, $urandom));
          n += 2;
        end else begin
          send(pixel_req(opcode_t'($urandom_range(0, 1)), ch, idx, $urandom));
          n++;
        end
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("bitplane_led_pixel_store verification clean");
    end else begin
      $display("bitplane_led_pixel_store verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/blps_pkg.sv
sv/blps_ctrl.sv
sv/blps_datapath.sv
sv/bitplane_led_pixel_store.sv
verif/pixel_store_checker.sv
verif/tb.sv
